/* rtl/gacuv_pkg.sv */
package gacuv_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int SIZE_W  = 14;
  localparam int CNT_W   = 8;
  localparam int CODE_W  = 8;
  localparam int PITCH_W = SIZE_W + 1;
  localparam int OUT_W   = 17;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int TDATA_W = 72;

  typedef enum logic [2:0] {
    REG_ATLAS_WIDTH  = 3'd0,
    REG_ATLAS_HEIGHT = 3'd1,
    REG_GRID_COLUMNS = 3'd2,
    REG_GRID_ROWS    = 3'd3,
    REG_MARGIN_X     = 3'd4,
    REG_MARGIN_Y     = 3'd5
  } reg_idx_e;

  // derived geometry, constant between configuration writes
  typedef struct packed {
    logic                 ready;
    logic                 bad;
    logic [2*CNT_W-1:0]   cell_cnt;
    logic [CNT_W-1:0]     cols;
    logic [SIZE_W-1:0]    atlas_w;
    logic [SIZE_W-1:0]    atlas_h;
    logic [PITCH_W-1:0]   pitch_w;
    logic [PITCH_W-1:0]   pitch_h;
    logic [OUT_W-1:0]     cell_w_frac;
    logic [OUT_W-1:0]     cell_h_frac;
  } cfg_t;

  // one restoring division step: returns {quotient bit, new remainder}
  function automatic logic [SIZE_W:0] div_step(input logic [SIZE_W-1:0] rem,
                                               input logic din,
                                               input logic [SIZE_W-1:0] dvs);
    logic [SIZE_W:0] t;
    t = {rem, din};
    if (t >= {1'b0, dvs}) begin
      div_step = {1'b1, SIZE_W'(t - {1'b0, dvs})};
    end else begin
      div_step = {1'b0, t[SIZE_W-1:0]};
    end
  endfunction

endpackage

/* rtl/gacuv_regs.sv */
module gacuv_regs #(
  parameter int FRAC_BITS = gacuv_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gacuv_pkg::ADDR_W-1:0] paddr,
  input  logic [gacuv_pkg::DATA_W-1:0] pwdata,
  output logic [gacuv_pkg::DATA_W-1:0] prdata,
  output gacuv_pkg::cfg_t             cfg_o
);
  import gacuv_pkg::*;

  localparam int QW  = (FRAC_BITS + 1 > SIZE_W) ? FRAC_BITS + 1 : SIZE_W;
  localparam int ITN = (FRAC_BITS > SIZE_W) ? FRAC_BITS : SIZE_W;
  localparam int ITW = $clog2(ITN);

  typedef enum logic [6:0] {
    ST_GAP   = 7'b0000001,
    ST_SPAN  = 7'b0000010,
    ST_CDIV  = 7'b0000100,
    ST_FINIT = 7'b0001000,
    ST_FDIV  = 7'b0010000,
    ST_ROUND = 7'b0100000,
    ST_DONE  = 7'b1000000
  } prep_state_e;

  logic [SIZE_W-1:0] aw_q, ah_q;
  logic [CNT_W-1:0]  cols_q, rows_q, mx_q, my_q;

  prep_state_e       state_q;
  logic [ITW-1:0]    it_q;
  logic [2*CNT_W-1:0] gap_w_q, gap_h_q, cnt_q;
  logic              bad_q;
  logic [SIZE_W-1:0] num_w_q, num_h_q, rem_w_q, rem_h_q;
  logic [QW-1:0]     q_w_q, q_h_q;
  logic [PITCH_W-1:0] pitch_w_q, pitch_h_q;
  logic [OUT_W-1:0]  fw_q, fh_q;

  logic              wr;
  reg_idx_e          idx;
  logic [CNT_W-1:0]  cols_m1, rows_m1;
  logic [SIZE_W:0]   step_w, step_h;
  logic [SIZE_W-1:0] cell_w, cell_h;
  logic              top_w, top_h, rnd_w, rnd_h;
  logic [FRAC_BITS:0] fw_sum, fh_sum;

  assign wr  = psel & penable & pwrite;
  assign idx = reg_idx_e'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aw_q   <= '0;
      ah_q   <= '0;
      cols_q <= '0;
      rows_q <= '0;
      mx_q   <= '0;
      my_q   <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_ATLAS_WIDTH:  aw_q   <= pwdata[SIZE_W-1:0];
        REG_ATLAS_HEIGHT: ah_q   <= pwdata[SIZE_W-1:0];
        REG_GRID_COLUMNS: cols_q <= pwdata[CNT_W-1:0];
        REG_GRID_ROWS:    rows_q <= pwdata[CNT_W-1:0];
        REG_MARGIN_X:     mx_q   <= pwdata[CNT_W-1:0];
        REG_MARGIN_Y:     my_q   <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ATLAS_WIDTH:  prdata = DATA_W'(aw_q);
      REG_ATLAS_HEIGHT: prdata = DATA_W'(ah_q);
      REG_GRID_COLUMNS: prdata = DATA_W'(cols_q);
      REG_GRID_ROWS:    prdata = DATA_W'(rows_q);
      REG_MARGIN_X:     prdata = DATA_W'(mx_q);
      REG_MARGIN_Y:     prdata = DATA_W'(my_q);
      default:          prdata = '0;
    endcase
  end

  // one shared step unit per axis: cell size first, then cell fraction
  assign cols_m1 = cols_q - 8'd1;
  assign rows_m1 = rows_q - 8'd1;
  assign step_w = (state_q == ST_CDIV) ?
                  div_step(rem_w_q, num_w_q[SIZE_W-1], SIZE_W'(cols_q)) :
                  div_step(rem_w_q, 1'b0, aw_q);
  assign step_h = (state_q == ST_CDIV) ?
                  div_step(rem_h_q, num_h_q[SIZE_W-1], SIZE_W'(rows_q)) :
                  div_step(rem_h_q, 1'b0, ah_q);
  assign cell_w = q_w_q[SIZE_W-1:0];
  assign cell_h = q_h_q[SIZE_W-1:0];
  assign top_w  = cell_w >= aw_q;
  assign top_h  = cell_h >= ah_q;
  assign rnd_w  = ({1'b0, rem_w_q} + {2'b0, aw_q[SIZE_W-1:1]}) >= {1'b0, aw_q};
  assign rnd_h  = ({1'b0, rem_h_q} + {2'b0, ah_q[SIZE_W-1:1]}) >= {1'b0, ah_q};
  assign fw_sum = q_w_q[FRAC_BITS:0] + (FRAC_BITS+1)'(rnd_w);
  assign fh_sum = q_h_q[FRAC_BITS:0] + (FRAC_BITS+1)'(rnd_h);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_GAP;
      it_q    <= '0;
    end else if (wr) begin
      state_q <= ST_GAP;
    end else begin
      unique case (state_q)
        ST_GAP:  state_q <= ST_SPAN;
        ST_SPAN: begin
          state_q <= ST_CDIV;
          it_q    <= '0;
        end
        ST_CDIV: begin
          it_q <= it_q + 1'b1;
          if (it_q == ITW'(SIZE_W - 1)) state_q <= ST_FINIT;
        end
        ST_FINIT: begin
          state_q <= ST_FDIV;
          it_q    <= '0;
        end
        ST_FDIV: begin
          it_q <= it_q + 1'b1;
          if (it_q == ITW'(FRAC_BITS - 1)) state_q <= ST_ROUND;
        end
        ST_ROUND: state_q <= ST_DONE;
        ST_DONE:  state_q <= ST_DONE;
        default:  state_q <= ST_GAP;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_GAP: begin
        gap_w_q <= cols_m1 * mx_q;
        gap_h_q <= rows_m1 * my_q;
        cnt_q   <= cols_q * rows_q;
      end
      ST_SPAN: begin
        bad_q   <= (aw_q == '0) || (ah_q == '0) || (cols_q == '0) || (rows_q == '0) ||
                   (gap_w_q >= (2*CNT_W)'(aw_q)) || (gap_h_q >= (2*CNT_W)'(ah_q));
        num_w_q <= aw_q - gap_w_q[SIZE_W-1:0];
        num_h_q <= ah_q - gap_h_q[SIZE_W-1:0];
        rem_w_q <= '0;
        rem_h_q <= '0;
        q_w_q   <= '0;
        q_h_q   <= '0;
      end
      ST_CDIV, ST_FDIV: begin
        rem_w_q <= step_w[SIZE_W-1:0];
        rem_h_q <= step_h[SIZE_W-1:0];
        q_w_q   <= {q_w_q[QW-2:0], step_w[SIZE_W]};
        q_h_q   <= {q_h_q[QW-2:0], step_h[SIZE_W]};
        num_w_q <= {num_w_q[SIZE_W-2:0], 1'b0};
        num_h_q <= {num_h_q[SIZE_W-2:0], 1'b0};
      end
      ST_FINIT: begin
        pitch_w_q <= {1'b0, cell_w} + PITCH_W'(mx_q);
        pitch_h_q <= {1'b0, cell_h} + PITCH_W'(my_q);
        rem_w_q   <= top_w ? cell_w - aw_q : cell_w;
        rem_h_q   <= top_h ? cell_h - ah_q : cell_h;
        q_w_q     <= QW'(top_w);
        q_h_q     <= QW'(top_h);
      end
      ST_ROUND: begin
        fw_q <= OUT_W'(fw_sum);
        fh_q <= OUT_W'(fh_sum);
      end
      default: ;
    endcase
  end

  assign cfg_o.ready       = (state_q == ST_DONE);
  assign cfg_o.bad         = bad_q;
  assign cfg_o.cell_cnt    = cnt_q;
  assign cfg_o.cols        = cols_q;
  assign cfg_o.atlas_w     = aw_q;
  assign cfg_o.atlas_h     = ah_q;
  assign cfg_o.pitch_w     = pitch_w_q;
  assign cfg_o.pitch_h     = pitch_h_q;
  assign cfg_o.cell_w_frac = fw_q;
  assign cfg_o.cell_h_frac = fh_q;

endmodule

/* rtl/gacuv_lane.sv */
module gacuv_lane #(
  parameter int FRAC_BITS = gacuv_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [gacuv_pkg::SIZE_W-1:0] pix_i,
  input  logic [gacuv_pkg::SIZE_W-1:0] den_i,
  output logic [gacuv_pkg::OUT_W-1:0]  frac_o
);
  import gacuv_pkg::*;

  localparam int STEPS = 4;
  localparam int NST   = (FRAC_BITS + STEPS - 1) / STEPS;
  localparam int QW    = FRAC_BITS + 1;

  logic [SIZE_W-1:0] rem_q [NST];
  logic [QW-1:0]     q_q   [NST];

  for (genvar k = 0; k < NST; k++) begin : g_stage
    logic [SIZE_W-1:0] rem_d;
    logic [QW-1:0]     q_d;
    logic [SIZE_W-1:0] rin;
    logic [QW-1:0]     qin;

    if (k == 0) begin : g_init
      // pix never exceeds den on a good request, so one leading bit suffices
      assign rin = (pix_i >= den_i) ? pix_i - den_i : pix_i;
      assign qin = QW'(pix_i >= den_i);
    end else begin : g_chain
      assign rin = rem_q[k-1];
      assign qin = q_q[k-1];
    end

    always_comb begin
      logic [SIZE_W:0] st;
      rem_d = rin;
      q_d   = qin;
      for (int i = 0; i < STEPS; i++) begin
        if (k * STEPS + i < FRAC_BITS) begin
          st    = div_step(rem_d, 1'b0, den_i);
          rem_d = st[SIZE_W-1:0];
          q_d   = {q_d[QW-2:0], st[SIZE_W]};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        q_q[k]   <= q_d;
      end
    end
  end

  logic            rnd;
  logic [QW-1:0]   sum;

  // round half up from the final remainder
  assign rnd    = ({1'b0, rem_q[NST-1]} + {2'b0, den_i[SIZE_W-1:1]}) >= {1'b0, den_i};
  assign sum    = q_q[NST-1] + QW'(rnd);
  assign frac_o = OUT_W'(sum);

endmodule

/* rtl/glyph_atlas_cell_uv_top.sv */
// Glyph atlas cell lookup. Each char_code transfer returns the cell's width, height and top-left
// corner as fractions of the atlas size, or bad_request with zero fields. One item is accepted
// every cycle while the output is not stalled and the geometry is ready; the fraction dividers
// resolve four quotient bits per pipeline stage. After reset and after every register write the
// block recomputes cell size, pitch and cell fractions with its serial dividers, and holds
// s_axis_tready low meanwhile.
module glyph_atlas_cell_uv_top #(
  parameter int FRAC_BITS = gacuv_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [gacuv_pkg::CODE_W-1:0]  s_axis_tdata,  // char_code
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // cell_w_frac, cell_h_frac, origin_u, origin_v, zero pad
  output logic [gacuv_pkg::TDATA_W-1:0] m_axis_tdata,
  output logic [0:0]                    m_axis_tuser,  // bad_request
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gacuv_pkg::ADDR_W-1:0]  paddr,
  input  logic [gacuv_pkg::DATA_W-1:0]  pwdata,
  output logic [gacuv_pkg::DATA_W-1:0]  prdata,
  output logic                          pready
);
  import gacuv_pkg::*;

  localparam int NST = (FRAC_BITS + 3) / 4;
  localparam int LAT = 4 + NST;
  localparam int HALF = CODE_W / 2;

  cfg_t cfg;

  gacuv_regs #(.FRAC_BITS(FRAC_BITS)) u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  assign pready = 1'b1;

  logic en;
  logic vld_q [LAT];
  logic bad_q [LAT];
  logic out_v_q;
  logic [TDATA_W-1:0] out_data_q;
  logic out_bad_q;

  logic [CODE_W-1:0]  code0_q;
  logic [CODE_W-1:0]  rem1_q;
  logic [HALF-1:0]    q1_q, low1_q;
  logic [CODE_W-1:0]  col2_q, row2_q;
  logic [SIZE_W-1:0]  pu3_q, pv3_q;

  logic [CODE_W-1:0]  rem1_d, rem2_d;
  logic [HALF-1:0]    q1_d, q2_d;
  logic [CODE_W+PITCH_W-1:0] pu_m, pv_m;
  logic [OUT_W-1:0]   fu, fv;
  logic               bad_in;

  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en && cfg.ready;
  assign bad_in        = cfg.bad || ((2*CNT_W)'(s_axis_tdata) >= cfg.cell_cnt);

  // code / columns, four quotient bits per stage
  always_comb begin
    logic [SIZE_W:0]   st;
    logic [SIZE_W-1:0] r;
    r = '0;
    q1_d = '0;
    for (int i = 0; i < HALF; i++) begin
      st = div_step(r, code0_q[CODE_W-1-i], SIZE_W'(cfg.cols));
      r  = st[SIZE_W-1:0];
      q1_d[HALF-1-i] = st[SIZE_W];
    end
    rem1_d = r[CODE_W-1:0];
  end

  always_comb begin
    logic [SIZE_W:0]   st;
    logic [SIZE_W-1:0] r;
    r = SIZE_W'(rem1_q);
    q2_d = '0;
    for (int i = 0; i < HALF; i++) begin
      st = div_step(r, low1_q[HALF-1-i], SIZE_W'(cfg.cols));
      r  = st[SIZE_W-1:0];
      q2_d[HALF-1-i] = st[SIZE_W];
    end
    rem2_d = r[CODE_W-1:0];
  end

  // column and row offsets never pass the atlas size on a good request
  assign pu_m = col2_q * cfg.pitch_w;
  assign pv_m = row2_q * cfg.pitch_h;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LAT; i++) vld_q[i] <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      vld_q[0] <= s_axis_tvalid && cfg.ready;
      for (int i = 1; i < LAT; i++) vld_q[i] <= vld_q[i-1];
      out_v_q <= vld_q[LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      code0_q  <= s_axis_tdata;
      bad_q[0] <= bad_in;
      for (int i = 1; i < LAT; i++) bad_q[i] <= bad_q[i-1];
      rem1_q <= rem1_d;
      q1_q   <= q1_d;
      low1_q <= code0_q[HALF-1:0];
      col2_q <= rem2_d;
      row2_q <= {q1_q, q2_d};
      pu3_q  <= pu_m[SIZE_W-1:0];
      pv3_q  <= pv_m[SIZE_W-1:0];
      out_bad_q <= bad_q[LAT-1];
      if (bad_q[LAT-1]) begin
        out_data_q <= '0;
      end else begin
        out_data_q <= {(TDATA_W-4*OUT_W)'(0), fv, fu, cfg.cell_h_frac, cfg.cell_w_frac};
      end
    end
  end

  gacuv_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_u (
    .clk_i  (clk_i),
    .en_i   (en),
    .pix_i  (pu3_q),
    .den_i  (cfg.atlas_w),
    .frac_o (fu)
  );

  gacuv_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_v (
    .clk_i  (clk_i),
    .en_i   (en),
    .pix_i  (pv3_q),
    .den_i  (cfg.atlas_h),
    .frac_o (fv)
  );

  assign m_axis_tvalid   = out_v_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_bad_q;

endmodule

/* rtl/gacuv_checker.sv */
module gacuv_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [gacuv_pkg::TDATA_W-1:0] m_axis_tdata,
  input logic [0:0]                    m_axis_tuser,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // rejected requests carry all-zero fields
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("rejected request with nonzero fields");

  // a register write starts the geometry recompute, no input taken meanwhile
  a_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite |=> !s_axis_tready)
    else $error("input ready right after register write");

endmodule

bind glyph_atlas_cell_uv_top gacuv_checker u_gacuv_checker (.*);

/* tb/tb_glyph_atlas_cell_uv_top.sv */
module tb_glyph_atlas_cell_uv_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gacuv_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [OUT_W-1:0] w;
    logic [OUT_W-1:0] h;
    logic [OUT_W-1:0] u;
    logic [OUT_W-1:0] v;
    logic             bad;
  } cell_uv_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [CODE_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  glyph_atlas_cell_uv_top dut (.*);

  // shadow copy of the geometry registers
  logic [SIZE_W-1:0] atl_w, atl_h;
  logic [CNT_W-1:0] cols, rows, mar_x, mar_y;

  cell_uv_t expected_cells[$];
  int errors = 0;
  longint cycles = 0;
  bit stall_free = 1'b0;

  initial forever #10 clk_i = ~clk_i;

  function automatic logic [OUT_W-1:0] frac_of(longint unsigned pix, longint unsigned den);
    longint unsigned one, q;
    one = 64'd1 << FB;
    if (den == 0) return '0;
    q = (pix * one + den / 2) / den;
    if (q > one) q = one;
    return q[OUT_W-1:0];
  endfunction

  function automatic cell_uv_t locate_cell(logic [CODE_W-1:0] code);
    cell_uv_t r;
    int unsigned gw, gh, cw, ch;
    r = '0;
    if (atl_w == 0 || atl_h == 0 || cols == 0 || rows == 0 ||
        32'(code) >= 32'(cols) * 32'(rows)) begin
      r.bad = 1'b1;
      return r;
    end
    gw = (cols - 1) * mar_x;
    gh = (rows - 1) * mar_y;
    if (gw >= atl_w || gh >= atl_h) begin
      r.bad = 1'b1;
      return r;
    end
    cw = (atl_w - gw) / cols;
    ch = (atl_h - gh) / rows;
    r.w = frac_of(cw, atl_w);
    r.h = frac_of(ch, atl_h);
    r.u = frac_of((code % cols) * (cw + mar_x), atl_w);
    r.v = frac_of((code / cols) * (ch + mar_y), atl_h);
    return r;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    cell_uv_t got, exp_c;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.w = m_axis_tdata[16:0];
      got.h = m_axis_tdata[33:17];
      got.u = m_axis_tdata[50:34];
      got.v = m_axis_tdata[67:51];
      got.bad = m_axis_tuser[0];
      if (expected_cells.size() == 0) begin
        $display("%0t unexpected result actual %h", $time, got);
        errors++;
      end else begin
        exp_c = expected_cells.pop_front();
        if (got.w !== exp_c.w) begin
          $display("%0t cell_w_frac expected %h actual %h", $time, exp_c.w, got.w); errors++;
        end
        if (got.h !== exp_c.h) begin
          $display("%0t cell_h_frac expected %h actual %h", $time, exp_c.h, got.h); errors++;
        end
        if (got.u !== exp_c.u) begin
          $display("%0t origin_u expected %h actual %h", $time, exp_c.u, got.u); errors++;
        end
        if (got.v !== exp_c.v) begin
          $display("%0t origin_v expected %h actual %h", $time, exp_c.v, got.v); errors++;
        end
        if (got.bad !== exp_c.bad) begin
          $display("%0t bad_request expected %b actual %b", $time, exp_c.bad, got.bad); errors++;
        end
        if (m_axis_tdata[71:68] !== 4'd0) begin
          $display("%0t pad expected 0 actual %h", $time, m_axis_tdata[71:68]); errors++;
        end
      end
    end
  end

  // receiver stalls
  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      if (stall_free) m_axis_tready <= 1'b1;
      else begin
        n = $urandom_range(0, 12);
        if (($urandom_range(0, 3) == 0) || n == 0) m_axis_tready <= 1'b1;
        else begin
          m_axis_tready <= 1'b0;
          repeat (n) @(negedge clk_i);
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  task automatic send_code(logic [CODE_W-1:0] code, bit no_gap = 1'b0);
    int gap;
    gap = no_gap ? 0 : (($urandom_range(0, 2) == 0) ? $urandom_range(0, 12) : 0);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= code;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_cells.push_back(locate_cell(code));
    @(negedge clk_i);
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    s_axis_tvalid <= 1'b0;
    while (expected_cells.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [DATA_W-1:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_W'(4 * idx); pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_ATLAS_WIDTH:  atl_w = val[SIZE_W-1:0];
      REG_ATLAS_HEIGHT: atl_h = val[SIZE_W-1:0];
      REG_GRID_COLUMNS: cols = val[CNT_W-1:0];
      REG_GRID_ROWS:    rows = val[CNT_W-1:0];
      REG_MARGIN_X:     mar_x = val[CNT_W-1:0];
      default:          mar_y = val[CNT_W-1:0];
    endcase
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic set_geometry(int w, int h, int c, int r, int mx, int my);
    drain();
    write_reg(REG_ATLAS_WIDTH, w);
    write_reg(REG_ATLAS_HEIGHT, h);
    write_reg(REG_GRID_COLUMNS, c);
    write_reg(REG_GRID_ROWS, r);
    write_reg(REG_MARGIN_X, mx);
    write_reg(REG_MARGIN_Y, my);
  endtask

  task automatic test_reset_state;
    send_code(8'd0);
    send_code(8'hFF);
  endtask

  task automatic test_directed;
    set_geometry(512, 256, 16, 8, 2, 3);
    send_code(8'd0); send_code(8'd15); send_code(8'd16); send_code(8'd127);
    send_code(8'd128); send_code(8'hFF);
    set_geometry(16383, 16383, 255, 255, 0, 0);
    send_code(8'd0); send_code(8'hFE); send_code(8'hFF);
    set_geometry(1, 1, 1, 1, 255, 255);
    send_code(8'd0); send_code(8'd1);
    // tiny cells: span below count
    set_geometry(10, 10, 20, 20, 0, 0);
    send_code(8'd0); send_code(8'd199);
    // margins eat the whole span
    set_geometry(100, 100, 11, 4, 10, 1);
    send_code(8'd3);
    set_geometry(100, 100, 4, 11, 1, 10);
    send_code(8'd3);
    set_geometry(0, 50, 4, 4, 0, 0);
    send_code(8'd1);
    set_geometry(50, 50, 0, 4, 0, 0);
    send_code(8'd1);
    set_geometry(50, 50, 4, 0, 0, 0);
    send_code(8'd1);
  endtask

  task automatic test_random_phase(int n);
    int c, r;
    c = $urandom_range(1, 255);
    r = $urandom_range(1, 255);
    if ($urandom_range(0, 1)) begin c = $urandom_range(1, 24); r = $urandom_range(1, 24); end
    set_geometry($urandom_range(0, 7) == 0 ? $urandom_range(0, 16383) : $urandom_range(256, 16383),
                 $urandom_range(0, 7) == 0 ? $urandom_range(0, 16383) : $urandom_range(256, 16383),
                 c, r, $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 8),
                 $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 8));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) != 0 && c * r > 0) send_code($urandom_range(0, c * r - 1 > 255 ? 255 : c * r - 1));
      else send_code($urandom_range(0, 255));
    end
  endtask

  task automatic test_back_to_back;
    set_geometry(1024, 1024, 16, 16, 1, 1);
    stall_free = 1'b1;
    for (int i = 0; i < 100; i++) send_code($urandom_range(0, 255), 1'b1);
    // hold until every result is back, then burst again
    drain();
    for (int i = 0; i < 50; i++) send_code($urandom_range(0, 255), 1'b1);
    stall_free = 1'b0;
  endtask

  initial begin
    atl_w = '0; atl_h = '0; cols = '0; rows = '0; mar_x = '0; mar_y = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_directed();
    test_back_to_back();
    for (int p = 0; p < 24; p++) test_random_phase(50);
    drain();
    if (errors == 0 && expected_cells.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

/* glyph_atlas_cell_uv_top.f */
rtl/gacuv_pkg.sv
rtl/gacuv_regs.sv
rtl/gacuv_lane.sv
rtl/glyph_atlas_cell_uv_top.sv
rtl/gacuv_checker.sv
tb/tb_glyph_atlas_cell_uv_top.sv
